### design/mrrc_pkg.sv
// Shared types, codes and helpers for the Modbus read-response checker.
package mrrc_pkg;

  // Default sizes
  localparam int DEF_BUFFER_BYTES = 20;
  localparam int DEF_SENSORS      = 8;

  // Action codes on the input channel
  localparam logic [1:0] ACT_BYTE      = 2'd0;
  localparam logic [1:0] ACT_SEND_FAIL = 2'd1;
  localparam logic [1:0] ACT_RECV_FAIL = 2'd2;
  localparam logic [1:0] ACT_NONE      = 2'd3;

  // Status codes on the result channel
  localparam logic [1:0] ST_ACCEPT    = 2'd0;
  localparam logic [1:0] ST_REJECT    = 2'd1;
  localparam logic [1:0] ST_SEND_FAIL = 2'd2;
  localparam logic [1:0] ST_RECV_FAIL = 2'd3;

  // Protocol constants
  localparam logic [15:0] CRC_START      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  READ_REGS_CODE = 8'd3;
  localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] sensor_index;
    logic [7:0] expected_address;
    logic [7:0] rx_byte;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    logic [2:0]  sensor_tag;
    logic [1:0]  status;
    logic [15:0] humidity_raw;
    logic [15:0] temperature_raw;
    logic [15:0] accepted_count;
    logic [15:0] rejected_count;
    logic [15:0] send_fail_count;
    logic [15:0] receive_fail_count;
  } out_t;

  // Finished transaction handed from the frame parser to the counter stage
  typedef struct packed {
    logic [2:0]  sensor;
    logic [1:0]  status;
    logic [15:0] hum;
    logic [15:0] temp;
  } ev_t;

  // One byte of reflected CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/mrrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, old data on a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/mrrc_frame.sv
// Reply byte parser: CRC, header capture and frame verdict.
module mrrc_frame import mrrc_pkg::*; #(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  in_t  in_data,
  output logic ev_fire,
  output ev_t  ev
);

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);
  localparam int CW    = 10;

  logic [15:0]      crc_r, crc_nxt, crc_new;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       bc_r, bc_nxt;
  logic [31:0]      word_r, word_nxt;
  logic             crc_ok_r, crc_ok_nxt;
  logic [CW-1:0]    pos_ext, need_cur, need_fin, pos_fin;
  logic [7:0]       lim_bc;
  logic             frame_ok;

  assign pos_ext = CW'(pos_r);
  assign lim_bc  = (pos_ext == CW'(2)) ? in_data.rx_byte : bc_r;
  assign need_cur = CW'({1'b0, lim_bc}) + CW'(FRAME_OVERHEAD);
  assign crc_new  = crc_byte(crc_r, in_data.rx_byte);

  // Verdict from the state after this byte
  assign need_fin = CW'({1'b0, bc_nxt}) + CW'(FRAME_OVERHEAD);
  assign pos_fin  = CW'(pos_nxt);
  assign frame_ok = (pos_fin >= CW'(3)) && (need_fin <= CW'(BUFFER_BYTES)) &&
                    (pos_fin >= need_fin) && (addr_nxt == in_data.expected_address) &&
                    (func_nxt == READ_REGS_CODE) && crc_ok_nxt;

  // Advance the frame state and emit a transaction when one finishes
  always_comb begin
    crc_nxt    = crc_r;
    pos_nxt    = pos_r;
    addr_nxt   = addr_r;
    func_nxt   = func_r;
    bc_nxt     = bc_r;
    word_nxt   = word_r;
    crc_ok_nxt = crc_ok_r;
    ev_fire    = 1'b0;
    ev.sensor  = in_data.sensor_index;
    ev.status  = ST_REJECT;
    ev.hum     = '0;
    ev.temp    = '0;
    if (accept) begin
      unique case (in_data.action)
        ACT_BYTE: begin
          if (pos_ext < CW'(BUFFER_BYTES)) begin
            priority if (pos_ext == CW'(0)) begin
              addr_nxt = in_data.rx_byte;
            end else if (pos_ext == CW'(1)) begin
              func_nxt = in_data.rx_byte;
            end else if (pos_ext == CW'(2)) begin
              bc_nxt = in_data.rx_byte;
            end else if (pos_ext == CW'(3)) begin
              word_nxt[31:24] = word_r[31:24] | in_data.rx_byte;
            end else if (pos_ext == CW'(4)) begin
              word_nxt[23:16] = word_r[23:16] | in_data.rx_byte;
            end else if (pos_ext == CW'(5)) begin
              word_nxt[15:8] = word_r[15:8] | in_data.rx_byte;
            end else if (pos_ext == CW'(6)) begin
              word_nxt[7:0] = word_r[7:0] | in_data.rx_byte;
            end else begin
              word_nxt = word_r;
            end
            if ((pos_ext < CW'(3)) || (pos_ext < need_cur)) begin
              crc_nxt = crc_new;
              if ((pos_ext >= CW'(2)) && ((pos_ext + CW'(1)) == need_cur)) begin
                crc_ok_nxt = (crc_new == 16'h0000);
              end
            end
            pos_nxt = pos_r + POS_W'(1);
          end
          if (in_data.frame_last) begin
            ev_fire = 1'b1;
            if (frame_ok) begin
              ev.status = ST_ACCEPT;
              ev.hum    = word_nxt[31:16];
              ev.temp   = word_nxt[15:0];
            end
          end
        end
        ACT_SEND_FAIL: begin
          ev_fire   = 1'b1;
          ev.status = ST_SEND_FAIL;
        end
        ACT_RECV_FAIL: begin
          ev_fire   = 1'b1;
          ev.status = ST_RECV_FAIL;
        end
        ACT_NONE: begin
          ev_fire = 1'b0;
        end
        default: begin
          ev_fire = 1'b0;
        end
      endcase
    end
  end

  // Hold the frame state; drop it once a transaction finishes
  always_ff @(posedge clk) begin
    if (!rst_n || ev_fire) begin
      crc_r    <= CRC_START;
      pos_r    <= '0;
      addr_r   <= '0;
      func_r   <= '0;
      bc_r     <= '0;
      word_r   <= '0;
      crc_ok_r <= 1'b0;
    end else begin
      crc_r    <= crc_nxt;
      pos_r    <= pos_nxt;
      addr_r   <= addr_nxt;
      func_r   <= func_nxt;
      bc_r     <= bc_nxt;
      word_r   <= word_nxt;
      crc_ok_r <= crc_ok_nxt;
    end
  end

endmodule

### design/mrrc_cnt.sv
// Per-sensor counter read-modify-write stage around the counter memory.
module mrrc_cnt import mrrc_pkg::*; #(
  parameter int SENSORS = DEF_SENSORS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic ev_fire,
  input  ev_t  ev,
  input  logic out_ready,
  output logic res_valid,
  output out_t res
);

  localparam int SLOT_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  logic [6:0]        slot_full;
  logic [SLOT_W-1:0] rd_slot;
  logic              s1_valid_r, s1_valid_nxt;
  ev_t               s1_ev_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              s1_init_r;
  logic              fwd_valid_r;
  logic [SLOT_W-1:0] fwd_slot_r;
  logic [63:0]       fwd_data_r;
  logic [SENSORS-1:0] ent_valid_r;
  logic [63:0]       ram_rd, cur, upd;
  logic              wr_en;

  // Fold the sensor index onto the counter slots
  always_comb begin
    slot_full = 7'(ev.sensor);
    for (int k = 0; k < 8; k++) begin
      if (slot_full >= 7'(SENSORS)) begin
        slot_full = slot_full - 7'(SENSORS);
      end
    end
  end
  assign rd_slot = SLOT_W'(slot_full);

  mrrc_ram #(
    .WIDTH(64),
    .DEPTH(SENSORS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_slot_r),
    .wr_data(upd),
    .rd_en  (ev_fire),
    .rd_addr(rd_slot),
    .rd_data(ram_rd)
  );

  // Pick forwarded data when the previous write hit the same slot
  always_comb begin
    if (fwd_valid_r && (fwd_slot_r == s1_slot_r)) begin
      cur = fwd_data_r;
    end else if (s1_init_r) begin
      cur = ram_rd;
    end else begin
      cur = '0;
    end
  end

  // Bump the counter that matches the status
  always_comb begin
    upd = cur;
    unique case (s1_ev_r.status)
      ST_ACCEPT:    upd[15:0]  = cur[15:0] + 16'd1;
      ST_REJECT:    upd[31:16] = cur[31:16] + 16'd1;
      ST_SEND_FAIL: upd[47:32] = cur[47:32] + 16'd1;
      ST_RECV_FAIL: upd[63:48] = cur[63:48] + 16'd1;
      default:      upd = cur;
    endcase
  end

  assign wr_en = s1_valid_r && out_ready;

  always_comb begin
    if (ev_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (wr_en) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Control state: stage valid, entry valid bits, forward valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      ent_valid_r <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (wr_en) begin
        ent_valid_r[s1_slot_r] <= 1'b1;
      end
      if (ev_fire) begin
        fwd_valid_r <= wr_en;
      end
    end
  end

  // Capture the transaction and the write that shares its read edge
  always_ff @(posedge clk) begin
    if (ev_fire) begin
      s1_ev_r    <= ev;
      s1_slot_r  <= rd_slot;
      s1_init_r  <= ent_valid_r[rd_slot];
      fwd_slot_r <= s1_slot_r;
      fwd_data_r <= upd;
    end
  end

  assign res_valid              = s1_valid_r;
  assign res.sensor_tag         = s1_ev_r.sensor;
  assign res.status             = s1_ev_r.status;
  assign res.humidity_raw       = s1_ev_r.hum;
  assign res.temperature_raw    = s1_ev_r.temp;
  assign res.accepted_count     = upd[15:0];
  assign res.rejected_count     = upd[31:16];
  assign res.send_fail_count    = upd[47:32];
  assign res.receive_fail_count = upd[63:48];

endmodule

### design/modbus_read_response_checker.sv
// Top level of the Modbus RTU read-registers reply checker.
// Takes one transaction per cycle: a reply byte, a send failure or a receive
// failure for one of SENSORS sensors. Reply bytes run through a CRC-16 and a
// header check in registers; the frame-end byte or a failure finishes a
// transaction, which then reads the sensor's four 16-bit counters from a
// SENSORS x 64 memory, bumps one and writes it back. A result is registered
// at the memory read, then in the output register; back-to-back updates
// of one sensor are forwarded, so the rate stays one transaction per cycle
// unless the result side stalls.
// Counters start at zero after reset through per-entry valid bits, so there
// is no clearing pass.
module modbus_read_response_checker import mrrc_pkg::*; #(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int SENSORS      = DEF_SENSORS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic accept;
  logic ev_fire;
  ev_t  ev;
  logic res_valid;
  out_t res;
  logic out_ready;
  logic out_valid_r;
  out_t out_data_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = res_valid && !out_ready;
  assign accept    = in_valid && !in_stall;

  mrrc_frame #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_data(in_data),
    .ev_fire(ev_fire),
    .ev     (ev)
  );

  mrrc_cnt #(
    .SENSORS(SENSORS)
  ) u_cnt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_fire  (ev_fire),
    .ev       (ev),
    .out_ready(out_ready),
    .res_valid(res_valid),
    .res      (res)
  );

  // Output register: load when free or taken, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/mrrc_checker.sv
// Port-level checks for the read-response checker, bound to the top level.
module mrrc_checker import mrrc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Data words are zero unless the frame was accepted
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_ACCEPT) |->
      (out_data.humidity_raw == 16'h0000) && (out_data.temperature_raw == 16'h0000))
    else $error("data words set on a non-accepted result");

  // Input side stalls only behind a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid after reset");

endmodule

bind modbus_read_response_checker mrrc_checker u_mrrc_checker (.*);
